[design/rwa_pkg.sv]
// ----------------------------------------------------------------------------
// rwa_pkg: shared types and constants of the running window average
// Holds the fixed field widths, register codes and the command and status
// structures that connect the controller and the datapath.
// ----------------------------------------------------------------------------
package rwa_pkg;

    // Fixed widths of the arithmetic and of the result fields.
    localparam int SUM_BITS     = 21;
    localparam int OUT_SUM_BITS = 20;
    localparam int OUT_AVG_BITS = 24;
    localparam int FRAC_BITS    = 8;
    localparam int QUO_BITS     = OUT_SUM_BITS + FRAC_BITS;
    localparam int WIN_BITS     = 5;
    localparam int SEEN_BITS    = 16;

    // Configuration port.
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [WIN_BITS-1:0] WINDOW_RESET = 5'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // take the input transaction into the sample register
        logic read_old;   // read the outgoing sample from the ring
        logic update;     // update sum, ring, position and counters
        logic div_start;  // saturate the sum and start the divider
        logic load_out;   // load the result register
    } rwa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;   // the divider has finished its last step
        logic out_free;   // the result register can take a new result
    } rwa_sts_t;

endpackage

[design/rwa_div.sv]
// ----------------------------------------------------------------------------
// rwa_div: restoring divider, one quotient bit per cycle
// Divides an unsigned dividend of QUO_BITS bits by an unsigned divisor of
// WIN_BITS bits and raises done for one cycle after the last step.
// ----------------------------------------------------------------------------
module rwa_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rwa_pkg::QUO_BITS-1:0] dividend,
    input  logic [rwa_pkg::WIN_BITS-1:0] divisor,
    output logic [rwa_pkg::QUO_BITS-1:0] quotient,
    output logic                         done
);
    import rwa_pkg::*;

    localparam int CNT_BITS = $clog2(QUO_BITS + 1);

    logic [QUO_BITS-1:0] q_reg, q_next;
    logic [WIN_BITS-1:0] rem_reg, rem_next;
    logic [WIN_BITS-1:0] dvs_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [WIN_BITS:0]   shifted;
    logic [WIN_BITS+1:0] trial;

    always_comb
    begin
        shifted   = {rem_reg, q_reg[QUO_BITS-1]};
        trial     = {1'b0, shifted} - {2'b00, dvs_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (cnt_reg != '0)
        begin
            if (trial[WIN_BITS+1] == 1'b0)
            begin
                rem_next = trial[WIN_BITS-1:0];
                q_next   = {q_reg[QUO_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WIN_BITS-1:0];
                q_next   = {q_reg[QUO_BITS-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_BITS'(QUO_BITS);
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

[design/rwa_datapath.sv]
// ----------------------------------------------------------------------------
// rwa_datapath: ring store, running sum, counters and result register
// Carries out the commands of the controller and holds the result until
// the output transaction completes.
// ----------------------------------------------------------------------------
module rwa_datapath #(
    parameter int DEPTH       = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rwa_pkg::rwa_cmd_t                    cmd,
    output rwa_pkg::rwa_sts_t                    sts,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    input  logic [rwa_pkg::WIN_BITS-1:0]         window_length,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [rwa_pkg::OUT_SUM_BITS-1:0] window_sum,
    output logic [rwa_pkg::WIN_BITS-1:0]         average_count,
    output logic signed [rwa_pkg::OUT_AVG_BITS-1:0] average_q8,
    output logic [rwa_pkg::SEEN_BITS-1:0]        samples_seen
);
    import rwa_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = AW + 2;
    localparam int EXT_W = (SAMPLE_BITS > SUM_BITS) ? SAMPLE_BITS : SUM_BITS;

    // Ring store; entries never written since reset read as zero.
    logic signed [SAMPLE_BITS-1:0] ring [DEPTH];
    logic [DEPTH-1:0]              ring_valid_reg;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] old_data_reg;
    logic                          old_valid_reg;
    logic [AW-1:0]                 wp_reg;
    logic [SUM_BITS-1:0]           sum_reg, sum_next;
    logic [SEEN_BITS-1:0]          seen_reg, seen_next;
    logic [WIN_BITS-1:0]           count_reg, count_next;
    logic signed [OUT_SUM_BITS-1:0] wsum_reg, wsum_next;
    logic                          out_valid_reg;
    logic signed [OUT_SUM_BITS-1:0] out_sum_reg;
    logic [WIN_BITS-1:0]           out_count_reg;
    logic signed [OUT_AVG_BITS-1:0] out_avg_reg;
    logic [SEEN_BITS-1:0]          out_seen_reg;

    logic [WIN_BITS-1:0]           win;
    logic [IW-1:0]                 idx_sum;
    logic [AW-1:0]                 old_idx;
    logic [AW-1:0]                 wp_inc;
    logic signed [EXT_W-1:0]       new_ext, old_ext;
    logic [OUT_SUM_BITS-1:0]       mag;
    logic [QUO_BITS-1:0]           dividend;
    logic [QUO_BITS-1:0]           quotient;
    logic                          div_done;
    logic signed [OUT_AVG_BITS-1:0] avg_sat;

    // Window in effect: zero acts as one, anything above DEPTH as DEPTH.
    always_comb
    begin
        priority if (window_length == '0)
            win = WIN_BITS'(1);
        else if (32'(window_length) > DEPTH)
            win = WIN_BITS'(DEPTH);
        else
            win = window_length;
    end

    // Index one window behind the write position, modulo DEPTH.
    always_comb
    begin
        idx_sum = IW'(wp_reg) + IW'(DEPTH) - IW'(win);
        if (idx_sum >= IW'(DEPTH))
            old_idx = AW'(idx_sum - IW'(DEPTH));
        else
            old_idx = AW'(idx_sum);
        wp_inc = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    end

    // Running sum, counters.
    always_comb
    begin
        new_ext   = EXT_W'(sample_reg);
        old_ext   = old_valid_reg ? EXT_W'(old_data_reg) : '0;
        sum_next  = sum_reg - old_ext[SUM_BITS-1:0] + new_ext[SUM_BITS-1:0];
        count_next = (seen_reg >= SEEN_BITS'(win)) ? win : WIN_BITS'(seen_reg + 1'b1);
        seen_next = (seen_reg == '1) ? seen_reg : seen_reg + 1'b1;
    end

    // Sum saturated to the output range and its magnitude scaled by 2^8.
    always_comb
    begin
        if (sum_reg[SUM_BITS-1] != sum_reg[SUM_BITS-2])
            wsum_next = sum_reg[SUM_BITS-1] ? {1'b1, {(OUT_SUM_BITS-1){1'b0}}}
                                            : {1'b0, {(OUT_SUM_BITS-1){1'b1}}};
        else
            wsum_next = sum_reg[OUT_SUM_BITS-1:0];
        mag      = wsum_next[OUT_SUM_BITS-1] ? OUT_SUM_BITS'(-wsum_next)
                                              : OUT_SUM_BITS'(wsum_next);
        dividend = {mag, {FRAC_BITS{1'b0}}};
    end

    // Signed average from the quotient magnitude, saturated to 24 bits.
    always_comb
    begin
        if (!wsum_reg[OUT_SUM_BITS-1])
        begin
            if (quotient > QUO_BITS'({1'b0, {(OUT_AVG_BITS-1){1'b1}}}))
                avg_sat = {1'b0, {(OUT_AVG_BITS-1){1'b1}}};
            else
                avg_sat = quotient[OUT_AVG_BITS-1:0];
        end
        else
        begin
            if (quotient > QUO_BITS'({1'b1, {(OUT_AVG_BITS-1){1'b0}}}))
                avg_sat = {1'b1, {(OUT_AVG_BITS-1){1'b0}}};
            else
                avg_sat = OUT_AVG_BITS'(-quotient);
        end
    end

    rwa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (count_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.update)
            ring[wp_reg] <= sample_reg;
        if (cmd.read_old)
            old_data_reg <= ring[old_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_valid_reg <= '0;
            old_valid_reg  <= 1'b0;
            wp_reg         <= '0;
            sum_reg        <= '0;
            seen_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.read_old)
                old_valid_reg <= ring_valid_reg[old_idx];
            if (cmd.update)
            begin
                ring_valid_reg[wp_reg] <= 1'b1;
                wp_reg   <= wp_inc;
                sum_reg  <= sum_next;
                seen_reg <= seen_next;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            sample_reg <= sample;
        if (cmd.update)
            count_reg <= count_next;
        if (cmd.div_start)
            wsum_reg <= wsum_next;
        if (cmd.load_out)
        begin
            out_sum_reg   <= wsum_reg;
            out_count_reg <= count_reg;
            out_avg_reg   <= avg_sat;
            out_seen_reg  <= seen_reg;
        end
    end

    assign sts.div_done  = div_done;
    assign sts.out_free  = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign window_sum    = out_sum_reg;
    assign average_count = out_count_reg;
    assign average_q8    = out_avg_reg;
    assign samples_seen  = out_seen_reg;

endmodule

[design/rwa_ctrl.sv]
// ----------------------------------------------------------------------------
// rwa_ctrl: sequencing state machine of the running window average
// Steps one transaction through read, update, divide and result load.
// ----------------------------------------------------------------------------
module rwa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rwa_pkg::rwa_sts_t sts,
    output rwa_pkg::rwa_cmd_t cmd
);
    import rwa_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_UPDATE = 6'b000100,
        S_START  = 6'b001000,
        S_DIVIDE = 6'b010000,
        S_FINISH = 6'b100000
    } rwa_state_t;

    rwa_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read_old = 1'b1;
                state_next   = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_START;
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (sts.div_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    // A result is only loaded when the output register can take it.
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded while the output register is occupied");

    // The divider only finishes while the controller waits for it.
    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_DIVIDE))
        else $error("divider finished outside the divide state");

    // An accepted transaction is followed by the ring read.
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> cmd.read_old)
        else $error("accepted transaction not followed by a ring read");
`endif

endmodule

[design/running_window_average.sv]
// ----------------------------------------------------------------------------
// running_window_average: moving average over a ring of recent samples
// Keeps the last DEPTH samples, a running sum over the configured window
// and a saturating sample count, and returns sum, count and Q.8 average.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  --------  ---------  --------------------  -----------------------------------
//  input     in         in_valid / in_stall   sample
//  output    out        out_valid / out_stall window_sum, average_count,
//                                             average_q8, samples_seen
//  config    in         APB psel / penable    window_length at address 0
//
// After acceptance the block reads the outgoing sample from the ring,
// updates the sum, loads the divider, runs one divider step per quotient
// bit, sees the divider finish and loads the result register once the
// output is free. The next sample is taken only after that load. The
// restoring divider yields one quotient bit per cycle. A new sample is
// taken while a finished result still waits on out_stall. Reset is
// asynchronous and active low; it clears the ring (through per-entry
// valid bits), the write position, the sum, the samples-seen counter
// and sets window_length to 4.
//
module running_window_average #(
    parameter int DEPTH       = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Input channel.
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [SAMPLE_BITS-1:0]           sample,
    // Output channel.
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [rwa_pkg::OUT_SUM_BITS-1:0] window_sum,
    output logic [rwa_pkg::WIN_BITS-1:0]            average_count,
    output logic signed [rwa_pkg::OUT_AVG_BITS-1:0] average_q8,
    output logic [rwa_pkg::SEEN_BITS-1:0]           samples_seen,
    // Configuration port.
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [rwa_pkg::APB_ADDR_BITS-1:0]       paddr,
    input  logic [rwa_pkg::APB_DATA_BITS-1:0]       pwdata,
    output logic [rwa_pkg::APB_DATA_BITS-1:0]       prdata,
    output logic                                    pready
);
    import rwa_pkg::*;

    logic [WIN_BITS-1:0] window_length_reg;
    logic                reg_sel;
    rwa_cmd_t            cmd;
    rwa_sts_t            sts;

    // The register index is the word address; only index zero exists.
    assign reg_sel = (paddr[APB_ADDR_BITS-1:2] == REG_WINDOW_LENGTH);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_length_reg <= WINDOW_RESET;
        else if (psel && penable && pwrite && pready && reg_sel)
            window_length_reg <= pwdata[WIN_BITS-1:0];
    end

    // Reads return the stored register value, unclamped.
    assign prdata = reg_sel ? APB_DATA_BITS'(window_length_reg) : '0;

    // The controller sequences each transaction; the datapath does the work.
    rwa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    rwa_datapath #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .sample        (sample),
        .window_length (window_length_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .window_sum    (window_sum),
        .average_count (average_count),
        .average_q8    (average_q8),
        .samples_seen  (samples_seen)
    );

endmodule

[test/running_window_average_checker.sv]
// ----------------------------------------------------------------------------
// running_window_average_checker: result predictor and scoreboard
// Watches the sample, result and register channels of the running window
// average, predicts every result from its own copy of the state and checks
// the results field by field in order.
// ----------------------------------------------------------------------------
module running_window_average_checker #(
    parameter int DEPTH       = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic signed [SAMPLE_BITS-1:0]           sample,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  logic signed [rwa_pkg::OUT_SUM_BITS-1:0] window_sum,
    input  logic [rwa_pkg::WIN_BITS-1:0]            average_count,
    input  logic signed [rwa_pkg::OUT_AVG_BITS-1:0] average_q8,
    input  logic [rwa_pkg::SEEN_BITS-1:0]           samples_seen,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [rwa_pkg::APB_ADDR_BITS-1:0]       paddr,
    input  logic [rwa_pkg::APB_DATA_BITS-1:0]       pwdata,
    input  logic [rwa_pkg::APB_DATA_BITS-1:0]       prdata,
    input  logic                                    pready,
    output int                                      pending,
    output int                                      mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import rwa_pkg::*;

    localparam logic [APB_ADDR_BITS-1:0] WINDOW_ADDR = {REG_WINDOW_LENGTH, 2'b00};
    localparam int unsigned SEEN_LIMIT = (1 << SEEN_BITS) - 1;

    typedef struct packed {
        logic signed [OUT_SUM_BITS-1:0] sum;
        logic [WIN_BITS-1:0]            count;
        logic signed [OUT_AVG_BITS-1:0] avg;
        logic [SEEN_BITS-1:0]           seen;
    } average_result_t;

    logic signed [SAMPLE_BITS-1:0] history [DEPTH];
    int unsigned                   wr_pos;
    logic signed [SUM_BITS-1:0]    sum_acc;
    int unsigned                   seen_total;
    logic [WIN_BITS-1:0]           window_reg;
    average_result_t               expected_averages [$];
    average_result_t               head;

    initial mismatches = 0;
    initial pending = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic longint signed saturate(input longint signed v, input int bits);
        longint signed hi;
        longint signed lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Advance the window state by one sample and queue the result it causes.
    task automatic take_sample(input logic signed [SAMPLE_BITS-1:0] s);
        int unsigned     w;
        int unsigned     old_pos;
        int unsigned     count;
        longint signed   sat_sum;
        longint signed   quot;
        average_result_t r;
        w = (window_reg == 0) ? 1 : ((window_reg > DEPTH) ? DEPTH : window_reg);
        old_pos = (wr_pos + DEPTH - w) % DEPTH;
        // The outgoing entry is read before the new sample lands, which
        // matters when the window spans the whole ring.
        sum_acc = sum_acc - history[old_pos] + s;
        history[wr_pos] = s;
        count = (seen_total >= w) ? w : seen_total + 1;
        if (seen_total < SEEN_LIMIT) seen_total++;
        wr_pos = (wr_pos + 1) % DEPTH;
        sat_sum = saturate(longint'(sum_acc), OUT_SUM_BITS);
        quot = (sat_sum * (longint'(1) <<< FRAC_BITS)) / longint'(count);
        r.sum = sat_sum[OUT_SUM_BITS-1:0];
        r.count = count[WIN_BITS-1:0];
        r.avg = saturate(quot, OUT_AVG_BITS);
        r.seen = seen_total[SEEN_BITS-1:0];
        expected_averages.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++) history[k] = '0;
            wr_pos = 0;
            sum_acc = '0;
            seen_total = 0;
            window_reg = WINDOW_RESET;
            expected_averages.delete();
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite && paddr == WINDOW_ADDR)
                    window_reg = pwdata[WIN_BITS-1:0];
                else if (!pwrite && paddr == WINDOW_ADDR
                         && prdata !== APB_DATA_BITS'(window_reg))
                    report_mismatch($sformatf("window_length read 0x%0h, expected 0x%0h",
                                              prdata, window_reg));
            end

            if (in_valid && !in_stall)
                take_sample(sample);

            if (out_valid && !out_stall)
            begin
                if (expected_averages.size() == 0)
                    report_mismatch("result transaction with none expected");
                else
                begin
                    head = expected_averages.pop_front();
                    if (window_sum !== head.sum)
                        report_mismatch($sformatf("window_sum %0d, expected %0d",
                                                  window_sum, head.sum));
                    if (average_count !== head.count)
                        report_mismatch($sformatf("average_count %0d, expected %0d",
                                                  average_count, head.count));
                    if (average_q8 !== head.avg)
                        report_mismatch($sformatf("average_q8 %0d, expected %0d",
                                                  average_q8, head.avg));
                    if (samples_seen !== head.seen)
                        report_mismatch($sformatf("samples_seen %0d, expected %0d",
                                                  samples_seen, head.seen));
                end
            end
        end
        pending = expected_averages.size();
    end

endmodule

[test/running_window_average_tb.sv]
// ----------------------------------------------------------------------------
// running_window_average_tb: stimulus and verdict for the running average
// Drives samples in random bursts, stalls the result side on a pattern of
// its own and reprograms the window between phases; the checker beside the
// block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module running_window_average_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rwa_pkg::*;

    localparam int DEPTH       = 16;
    localparam int SAMPLE_BITS = 16;

    // Register addresses. Only the window register is mapped; the spare
    // address holds no register and a write to it must change nothing.
    localparam logic [APB_ADDR_BITS-1:0] WINDOW_ADDR = {REG_WINDOW_LENGTH, 2'b00};
    localparam logic [APB_ADDR_BITS-1:0] SPARE_ADDR  = {~REG_WINDOW_LENGTH, 2'b00};

    localparam logic [SAMPLE_BITS-1:0] MAX_SAMPLE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] MIN_SAMPLE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // This pause lets any work in flight finish before a register write.
    localparam int DRAIN_CYCLES = 48;
    // A correct run's longest quiet stretch spans one transaction, the
    // longest result stall and the longest sender gap.
    localparam int IDLE_LIMIT   = 2000;
    localparam int ITEM_TARGET  = 500;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid;
    logic                            in_stall;
    logic signed [SAMPLE_BITS-1:0]   sample;
    logic                            out_valid;
    logic                            out_stall;
    logic signed [OUT_SUM_BITS-1:0]  window_sum;
    logic [WIN_BITS-1:0]             average_count;
    logic signed [OUT_AVG_BITS-1:0]  average_q8;
    logic [SEEN_BITS-1:0]            samples_seen;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [APB_ADDR_BITS-1:0]        paddr;
    logic [APB_DATA_BITS-1:0]        pwdata;
    logic [APB_DATA_BITS-1:0]        prdata;
    logic                            pready;

    int pending;
    int mismatches;
    int items_sent = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    // Receiver pattern state: a mode held for a random number of cycles,
    // and inside it runs of stalling or flowing.
    int stall_mode = 0;
    int mode_left = 0;
    int run_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    running_window_average #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .window_sum    (window_sum),
        .average_count (average_count),
        .average_q8    (average_q8),
        .samples_seen  (samples_seen),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    running_window_average_checker #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .window_sum    (window_sum),
        .average_count (average_count),
        .average_q8    (average_q8),
        .samples_seen  (samples_seen),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .pending       (pending),
        .mismatches    (mismatches)
    );

    // The result side stalls in phases: no stall at all, a coin toss every
    // cycle, or long runs of stalling and flowing. Each mode lasts a random
    // number of cycles so that stalls fall on every part of the block's work.
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(50, 300);
            out_stall <= 1'b0;
        end
        else
        begin
            mode_left <= mode_left - 1;
            if (stall_mode == 0)
                out_stall <= 1'b0;
            else if (stall_mode == 1)
                out_stall <= 1'($urandom_range(0, 1));
            else if (run_left == 0)
            begin
                out_stall <= !out_stall;
                run_left <= $urandom_range(1, 40);
            end
            else
                run_left <= run_left - 1;
        end
    end

    // Watchdog: counts cycles in which no transaction moves on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one sample and waits until the block takes it. The sender
    // works in bursts: valid stays high across a burst, and when a burst
    // ends it drops for a random gap before the next one.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        in_valid <= 1'b1;
        sample <= value;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            // Some bursts are long, giving stretches with no sender gaps.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Stops the sender and waits until every result has come back, then a
    // little longer so the block is surely idle. The pending count is read
    // at the falling edge, clear of the checker's update at the rising one.
    task automatic drain;
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes a register with the block idle, then reads the window register
    // back so the checker can compare it with the value in effect.
    task automatic configure(input logic [APB_ADDR_BITS-1:0] addr,
                             input logic [WIN_BITS-1:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= APB_DATA_BITS'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= WINDOW_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sample values: in half the flavors random across the full range, in the
    // others runs of extremes or of small values near zero.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int unsigned flavor);
        unique case (flavor)
            0:       return ($urandom_range(0, 1) == 1) ? MAX_SAMPLE : MIN_SAMPLE;
            1:       return SAMPLE_BITS'($urandom_range(0, 16) - 8);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    initial
    begin
        int unsigned    flavor;
        int             count;
        logic [WIN_BITS-1:0] win;
        logic           up;
        logic [SAMPLE_BITS-1:0] directed_samples [13];

        in_valid <= 1'b0;
        sample <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first with the window left at its reset value of
        // four: zero, both extremes, minus one and one, then a window full of
        // the largest sample followed by a window full of the smallest.
        directed_samples = '{'0, MAX_SAMPLE, MIN_SAMPLE, '1, SAMPLE_BITS'(1),
                             MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE,
                             MIN_SAMPLE, MIN_SAMPLE, MIN_SAMPLE, MIN_SAMPLE};
        foreach (directed_samples[k]) send_sample(directed_samples[k]);

        // A window of zero behaves as a window of one.
        configure(WINDOW_ADDR, '0);
        send_sample(SAMPLE_BITS'(16'h1234));
        send_sample(MIN_SAMPLE);

        // A window above the ring depth is clamped to the depth.
        configure(WINDOW_ADDR, '1);
        send_sample(MAX_SAMPLE);
        send_sample('1);
        send_sample(MIN_SAMPLE);

        // A window equal to the depth reads the outgoing sample from the
        // very slot the new sample is about to overwrite.
        configure(WINDOW_ADDR, WIN_BITS'(DEPTH));
        send_sample(MAX_SAMPLE);
        send_sample(MAX_SAMPLE);
        send_sample(SAMPLE_BITS'(5));

        // A write to the unmapped address must leave the window alone.
        configure(SPARE_ADDR, WIN_BITS'(2));
        send_sample(MIN_SAMPLE);
        send_sample(SAMPLE_BITS'(7));

        // Random phases, each with a fresh window. Now and then a ramp phase
        // pushes the running sum far out of range: a window of one fills the
        // ring with one extreme, then the full window swaps it for the other,
        // gaining a full sample swing per transaction. That drives the output
        // sum and average into saturation and, repeated, wraps the running
        // sum itself.
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                up = 1'($urandom_range(0, 1));
                configure(WINDOW_ADDR, WIN_BITS'(1));
                repeat (DEPTH) send_sample(up ? MIN_SAMPLE : MAX_SAMPLE);
                configure(WINDOW_ADDR, WIN_BITS'(DEPTH));
                repeat (DEPTH) send_sample(up ? MAX_SAMPLE : MIN_SAMPLE);
            end
            else
            begin
                // Mostly legal windows, sometimes zero or above the depth.
                if ($urandom_range(0, 5) == 0)
                    win = WIN_BITS'($urandom());
                else
                    win = WIN_BITS'($urandom_range(1, DEPTH));
                configure(WINDOW_ADDR, win);
                flavor = $urandom_range(0, 3);
                count = $urandom_range(5, 40);
                repeat (count) send_sample(pick_sample(flavor));
            end
        end

        // Wait for the last results, let the block settle, then judge.
        drain();
        @(negedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
design/rwa_pkg.sv
design/rwa_div.sv
design/rwa_datapath.sv
design/rwa_ctrl.sv
design/running_window_average.sv
test/running_window_average_checker.sv
test/running_window_average_tb.sv
